// File: sv/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared codes, defaults and controller/datapath interface types for the
// segment bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

  localparam int SEG_BITS      = 32;
  localparam int MAP_WORDS_DEF = 32;

  localparam logic [1:0] KIND_FIND = 2'd0;
  localparam logic [1:0] KIND_USED = 2'd1;
  localparam logic [1:0] KIND_FREE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new item from the input ports
    logic sweep;  // walk map words for a find or a mark
    logic clear;  // write one zero word of the post-reset clearing pass
  } sba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic imm;         // item on the ports finishes without touching the map
    logic sweep_done;  // current sweep finishes this cycle
    logic clear_done;  // last word of the clearing pass is written this cycle
  } sba_stat_t;

endpackage

`default_nettype wire

// File: sv/segment_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// segment_bitmap_allocator
// First-fit contiguous segment allocator over a used/free bitmap held in RAM.
// ----------------------------------------------------------------------------
// Sequencing: a find reads one map word per cycle from word 0 and stops at the first word
//   that completes a free run, or at the last map word; a mark walks the words it spans;
//   zero lengths, unused kinds and marks that start past the map end finish without a sweep.
// Throughput: one item at a time; for an item that walks the map, busy stays high until done.
// Reset: rst clears control state, then a clearing pass writes zero to every map word
//   with busy high. The receiver cannot stall done.
`default_nettype none

module segment_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  first_segment,
  input  wire logic [10:0] run_length,
  output logic             done,
  output logic      [1:0]  status,
  output logic      [9:0]  found_segment
);

  // Command and status between controller and datapath.
  sba_cmd_t  cmd;
  sba_stat_t stat;

  // Controller: owns the state machine, busy and the done strobe.
  sba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Datapath: decodes the item, walks the map, scans for free runs, applies
  // mark masks and holds the result until the next item completes.
  sba_dpath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .first_segment (first_segment),
    .run_length    (run_length),
    .status        (status),
    .found_segment (found_segment)
  );

endmodule

`default_nettype wire

// File: sv/sba_ram.sv
// ----------------------------------------------------------------------------
// sba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl
// Controller: clearing pass after reset, item acceptance, sweep sequencing
// and the one-cycle done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_ctrl
  import sba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  output logic           done,
  output sba_cmd_t       cmd,
  input  wire sba_stat_t stat
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP
  } state_t;

  state_t state;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd.load  = start && (state == ST_IDLE);
    cmd.sweep = (state == ST_SWEEP);
    cmd.clear = (state == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (stat.clear_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (stat.imm) begin
              done <= 1'b1;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (stat.sweep_done) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted item either finishes at once or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy || done)
    else $error("accepted item neither completed nor held busy");

  // No result comes out of the clearing pass.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) != ST_CLEAR)
    else $error("done strobe during clearing pass");

endmodule

`default_nettype wire

// File: sv/sba_dpath.sv
// ----------------------------------------------------------------------------
// sba_dpath
// Datapath: request decode, word walker, map RAM, per-word free-run scan,
// range masking for marks, and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_dpath
  import sba_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sba_cmd_t    cmd,
  output sba_stat_t        stat,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  first_segment,
  input  wire logic [10:0] run_length,
  output logic      [1:0]  status,
  output logic      [9:0]  found_segment
);

  localparam int TOTAL = MAP_WORDS * SEG_BITS;
  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCW   = $clog2(MAP_WORDS + 1);
  localparam int PW    = $clog2(TOTAL + 2048);

  // request decode
  logic          is_find;
  logic          is_mark;
  logic [PW-1:0] first_pos;
  logic [PW-1:0] end_pos;
  logic [PW-1:0] hi_pos;
  logic [PW-1:0] last_pos;
  logic          range_err;
  logic          imm_range;

  // latched request
  logic          find_q;
  logic          free_q;
  logic [10:0]   len_q;
  logic [AW-1:0] first_word_q;
  logic [4:0]    first_bit_q;
  logic [AW-1:0] last_word_q;
  logic [4:0]    last_bit_q;
  logic          range_err_q;
  logic [AW-1:0] stop_word;

  // walker
  logic [WCW-1:0] cnt;
  logic           issue;
  logic           rd_valid;
  logic [AW-1:0]  rd_word;
  logic [31:0]    rd_data;
  logic [10:0]    carry;

  // scan
  logic [31:0]   has_l [6];
  logic [4:0]    idx_l [6][32];
  logic [11:0]   run_len [32];
  logic [31:0]   hit;
  logic          hit_any;
  logic [4:0]    hit_idx;
  logic [11:0]   carry_out;
  logic [PW-1:0] start_pos;

  // mark
  logic [31:0] lo_mask;
  logic [31:0] hi_mask;
  logic [31:0] mark_mask;
  logic        ram_we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  always_comb begin
    is_find   = (kind == KIND_FIND);
    is_mark   = kind inside {KIND_USED, KIND_FREE};
    first_pos = PW'(first_segment);
    end_pos   = first_pos + PW'(run_length);
    range_err = (end_pos > PW'(TOTAL));
    hi_pos    = range_err ? PW'(TOTAL) : end_pos;
    last_pos  = hi_pos - PW'(1);
    imm_range = is_mark && (run_length != 11'd0) && (first_pos >= PW'(TOTAL));
  end

  assign issue = (cnt <= WCW'(stop_word));

  // Free-run scan of one word: locate the nearest used bit at or below each
  // position (log-step prefix), then the free-run length ending there.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      has_l[0][i] = rd_data[i];
      idx_l[0][i] = 5'(i);
    end
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 32; i++) begin
        if ((i >= (1 << k)) && !has_l[k][i]) begin
          has_l[k+1][i] = has_l[k][i - (1 << k)];
          idx_l[k+1][i] = idx_l[k][i - (1 << k)];
        end else begin
          has_l[k+1][i] = has_l[k][i];
          idx_l[k+1][i] = idx_l[k][i];
        end
      end
    end
    for (int i = 0; i < 32; i++) begin
      run_len[i] = has_l[5][i] ? (12'(i) - 12'(idx_l[5][i]))
                               : (12'(carry) + 12'(i + 1));
      hit[i]     = (run_len[i] >= 12'(len_q));
    end
    hit_any = |hit;
    hit_idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = 5'(i);
      end
    end
    carry_out = has_l[5][31] ? (12'd31 - 12'(idx_l[5][31])) : (12'(carry) + 12'd32);
    start_pos = PW'({rd_word, hit_idx}) + PW'(1) - PW'(len_q);
  end

  always_comb begin
    lo_mask   = (rd_word == first_word_q) ? (32'hFFFF_FFFF << first_bit_q) : '1;
    hi_mask   = (rd_word == last_word_q) ? (32'hFFFF_FFFF >> (5'd31 - last_bit_q)) : '1;
    mark_mask = lo_mask & hi_mask;
    ram_we    = cmd.clear || (cmd.sweep && rd_valid && !find_q);
    waddr     = cmd.clear ? cnt[AW-1:0] : rd_word;
    if (cmd.clear) begin
      wdata = '0;
    end else if (free_q) begin
      wdata = rd_data & ~mark_mask;
    end else begin
      wdata = rd_data | mark_mask;
    end
  end

  always_comb begin
    stat.imm        = !(is_find || is_mark) || (run_length == 11'd0) || imm_range;
    stat.clear_done = cmd.clear && (cnt == WCW'(MAP_WORDS - 1));
    stat.sweep_done = rd_valid && ((find_q && hit_any) || (rd_word == stop_word));
  end

  sba_ram #(
    .WIDTH (SEG_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // walker control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.sweep && issue;
      if (cmd.load) begin
        cnt      <= is_find ? '0 : WCW'(first_pos[AW+4:5]);
        rd_valid <= 1'b0;
      end else if (cmd.clear || (cmd.sweep && issue)) begin
        cnt <= cnt + WCW'(1);
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    rd_word <= cnt[AW-1:0];
    if (cmd.load) begin
      find_q       <= is_find;
      free_q       <= (kind == KIND_FREE);
      len_q        <= run_length;
      first_word_q <= first_pos[AW+4:5];
      first_bit_q  <= first_pos[4:0];
      last_word_q  <= last_pos[AW+4:5];
      last_bit_q   <= last_pos[4:0];
      range_err_q  <= range_err;
      stop_word    <= is_find ? AW'(MAP_WORDS - 1) : last_pos[AW+4:5];
      carry        <= '0;
    end else if (cmd.sweep && rd_valid && find_q) begin
      carry <= carry_out[10:0];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load && stat.imm) begin
      status        <= imm_range ? STATUS_RANGE : STATUS_OK;
      found_segment <= '0;
    end else if (cmd.sweep && stat.sweep_done) begin
      if (find_q) begin
        status        <= hit_any ? STATUS_OK : STATUS_FULL;
        found_segment <= hit_any ? start_pos[9:0] : 10'd0;
      end else begin
        status        <= range_err_q ? STATUS_RANGE : STATUS_OK;
        found_segment <= '0;
      end
    end
  end

  // A mark sweep writes back every word it has read.
  assert property (@(posedge clk) disable iff (rst)
      cmd.sweep && rd_valid && !find_q |-> ram_we)
    else $error("mark word read but not written back");

  // Mark write-backs stay within the requested word span.
  assert property (@(posedge clk) disable iff (rst)
      cmd.sweep && ram_we |-> rd_word >= first_word_q && rd_word <= last_word_q)
    else $error("mark write outside requested span");

  // A find that hits reports ok.
  assert property (@(posedge clk) disable iff (rst)
      cmd.sweep && stat.sweep_done && find_q && hit_any |=> status == STATUS_OK)
    else $error("find hit not reported as ok");

endmodule

`default_nettype wire

// File: tb/segment_bitmap_checker.sv
// ----------------------------------------------------------------------------
// segment_bitmap_checker
// Watches the request and reply channels of the segment bitmap allocator,
// keeps its own copy of the segment map, and compares each reply with the
// oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_bitmap_checker
  import sba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  first_segment,
  input  wire logic [10:0] run_length,
  input  wire logic        done,
  input  wire logic [1:0]  status,
  input  wire logic [9:0]  found_segment,
  output int               fail_count,
  output int               owed_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_SEGS   = MAP_WORDS_DEF * SEG_BITS;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found;
  } seg_reply_t;

  bit [MAP_SEGS-1:0] used_map;
  seg_reply_t        owed_replies[$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: allocator mismatch: %s", $time, what);
    mismatches++;
  endtask

  // First-fit scan from segment 0, or a set/clear walk over a range.
  function automatic seg_reply_t predict_reply(input logic [1:0] req_kind,
                                               input logic [9:0] req_first,
                                               input logic [10:0] req_len);
    seg_reply_t rep;
    int         left;
    int         pos;
    int         k;
    rep = '{status: STATUS_OK, found: '0};
    if (req_kind == KIND_FIND) begin
      left = req_len;
      pos  = 0;
      while (left > 0 && pos < MAP_SEGS) begin
        if (used_map[pos])
          left = req_len;
        else
          left--;
        pos++;
      end
      if (left == 0)
        rep.found = 10'(pos - int'(req_len));
      else
        rep.status = STATUS_FULL;
    end else if (req_kind == KIND_USED || req_kind == KIND_FREE) begin
      k = 0;
      while (k < int'(req_len) && rep.status == STATUS_OK) begin
        pos = int'(req_first) + k;
        if (pos >= MAP_SEGS)
          rep.status = STATUS_RANGE;
        else
          used_map[pos] = (req_kind == KIND_USED);
        k++;
      end
    end
    return rep;
  endfunction

  task automatic check_reply(input logic [1:0] got_status, input logic [9:0] got_found);
    seg_reply_t oldest;
    if (owed_replies.size() == 0) begin
      report_mismatch($sformatf("reply with none owed: status %0d segment %0d",
                                got_status, got_found));
    end else begin
      oldest = owed_replies.pop_front();
      if (got_status !== oldest.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got_status, oldest.status));
      if (got_found !== oldest.found)
        report_mismatch($sformatf("found_segment %0d, predicted %0d",
                                  got_found, oldest.found));
    end
  endtask

  // Replies first: a reply at an edge always belongs to an earlier item.
  always @(posedge clk) begin
    if (rst) begin
      owed_replies.delete();
      used_map = '0;
      owed_count <= 0;
    end else begin
      if (done)
        check_reply(status, found_segment);
      if (start && !busy)
        owed_replies.push_back(predict_reply(kind, first_segment, run_length));
      owed_count <= owed_replies.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_segment_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// tb_segment_bitmap_allocator
// Drives find and mark items into the segment bitmap allocator: a directed
// pass over the corner cases, then random traffic in three idling phases.
// A checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_bitmap_allocator
  import sba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Unused kind code: the block must answer it with a plain ok.
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int MAP_SEGS      = MAP_WORDS_DEF * SEG_BITS;
  localparam int ITEMS_PER_RUN = 667;
  localparam int SETTLE_CYCLES = 2 * MAP_WORDS_DEF + 8;

  logic        clk;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic [1:0]  kind          = KIND_FIND;
  logic [9:0]  first_segment = '0;
  logic [10:0] run_length    = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  found_segment;
  int          fail_count;
  int          owed_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  segment_bitmap_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .first_segment (first_segment),
    .run_length    (run_length),
    .done          (done),
    .status        (status),
    .found_segment (found_segment)
  );

  segment_bitmap_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .first_segment (first_segment),
    .run_length    (run_length),
    .done          (done),
    .status        (status),
    .found_segment (found_segment),
    .fail_count    (fail_count),
    .owed_count    (owed_count)
  );

  // Present one item and hold it until the edge that takes it. Before it,
  // idle for a random stretch: each cycle idles with chance idle_pct in 100.
  // Return at the accepting edge with start still high, so a follow-on item
  // keeps start up without a low pulse.
  task automatic send_item(input logic [1:0] k, input logic [9:0] f,
                           input logic [10:0] l, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    kind          <= k;
    first_segment <= f;
    run_length    <= l;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every owed reply is back. The count from the
  // checker is registered and lags the queue, so always advance at least once.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  // Mostly short runs, some medium, a few up to the whole map and beyond.
  function automatic logic [10:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return 11'($urandom_range(24, 1));
    else if (r < 90)
      return 11'($urandom_range(200, 25));
    else if (r < 96)
      return 11'($urandom_range(MAP_SEGS, 201));
    else
      return 11'($urandom_range(2047, 0));
  endfunction

  // Corner cases: zero lengths, whole-map and oversize runs, ranges that run
  // off the map end, word-boundary runs, the unused kind, and every field
  // at its extremes.
  task automatic directed_items();
    send_item(KIND_FIND, 10'd0,   11'd0,    21);  // zero-length find
    send_item(KIND_FIND, 10'h3FF, 11'd1,    21);  // empty map: segment 0
    send_item(KIND_FIND, 10'd0,   11'd1024, 21);  // whole map fits
    send_item(KIND_FIND, 10'd0,   11'd1025, 21);  // longer than the map
    send_item(KIND_FIND, 10'h3FF, 11'h7FF,  21);
    send_item(KIND_USED, 10'd0,   11'd0,    21);  // zero-length mark
    send_item(KIND_USED, 10'd0,   11'd1024, 21);  // fill the map
    send_item(KIND_FIND, 10'd0,   11'd1,    21);  // nothing free
    send_item(KIND_FREE, 10'h3FF, 11'h7FF,  21);  // frees 1023, then off the end
    send_item(KIND_FIND, 10'd0,   11'd1,    21);  // last segment
    send_item(KIND_FIND, 10'd0,   11'd2,    21);
    send_item(KIND_FREE, 10'd0,   11'd1024, 21);  // clear all
    send_item(KIND_USED, 10'd1000, 11'd100, 21);  // sets 1000..1023, then off the end
    send_item(KIND_FIND, 10'd0,   11'd1000, 21);
    send_item(KIND_FIND, 10'd0,   11'd1001, 21);
    send_item(KIND_FREE, 10'd1000, 11'd24,  21);
    send_item(KIND_USED, 10'd31,  11'd2,    21);  // straddles words 0 and 1
    send_item(KIND_FIND, 10'd0,   11'd31,   21);
    send_item(KIND_FIND, 10'd0,   11'd32,   21);  // must start past the straddle
    send_item(KIND_NONE, 10'h3FF, 11'h7FF,  21);  // unused kind, map untouched
    send_item(KIND_FIND, 10'd0,   11'd32,   21);
    send_item(KIND_FREE, 10'd31,  11'd2,    21);
    send_item(KIND_USED, 10'h3FF, 11'd1,    21);  // last segment alone
    send_item(KIND_FREE, 10'h3FF, 11'd1,    21);
  endtask

  // Random mix: finds and marks with random ranges keep the map partly used,
  // so finds walk past used runs; rare whole-map fills and clears swing it.
  task automatic random_item(input int idle_pct);
    logic [1:0]  k;
    logic [9:0]  f;
    logic [10:0] l;
    int          r;
    r = $urandom_range(999);
    f = 10'($urandom_range(MAP_SEGS - 1));
    l = pick_length();
    if (r < 5) begin
      k = KIND_USED;
      f = '0;
      l = 11'(MAP_SEGS);
    end else if (r < 10) begin
      k = KIND_FREE;
      f = '0;
      l = 11'(MAP_SEGS);
    end else if (r < 420) begin
      k = KIND_FIND;
    end else if (r < 700) begin
      k = KIND_USED;
    end else if (r < 980) begin
      k = KIND_FREE;
    end else begin
      k = KIND_NONE;
    end
    send_item(k, f, l, idle_pct);
  endtask

  initial begin
    int idle_pct[3] = '{21, 80, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    // Pause the sender until the map is quiet before each random phase.
    foreach (idle_pct[p]) begin
      wait_drained();
      repeat (ITEMS_PER_RUN) random_item(idle_pct[p]);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_segment_bitmap_allocator passed");
    else
      $display("tb_segment_bitmap_allocator failed");
    $finish;
  end

  // Generous bound on the whole run; a hang ends here.
  initial begin
    #4_000_000;
    $display("tb_segment_bitmap_allocator failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/sba_pkg.sv
sv/sba_ram.sv
sv/sba_ctrl.sv
sv/sba_dpath.sv
sv/segment_bitmap_allocator.sv
tb/segment_bitmap_checker.sv
tb/tb_segment_bitmap_allocator.sv
